// ===== src/lowest_free_room_scheduler_assert.svh =====
// Assertion macros for the scheduler RTL, included by lfrs_back.
`ifndef LOWEST_FREE_ROOM_SCHEDULER_ASSERT_SVH
`define LOWEST_FREE_ROOM_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define LFRS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LFRS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/lfrs_pkg.sv =====
// ----------------------------------------------------------------------------
// lfrs_pkg
// Shared types and constants of the lowest-free-room scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package lfrs_pkg;

   localparam int ROOMS_DEF     = 16;
   localparam int TIME_BITS_DEF = 48;

   localparam int IN_TIME_W  = 40;
   localparam int COUNT_W    = 32;
   localparam int ROOM_OUT_W = 4;
   localparam int CFG_W      = 5;

   localparam logic [CFG_W-1:0] ROOM_COUNT_RST = 5'd16;

   // request queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   typedef struct packed {
      logic [IN_TIME_W-1:0] start_time;
      logic [IN_TIME_W-1:0] duration;
      logic                 last_request;
   } item_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_SCAN,
      B_UPDATE,
      B_REPORT,
      B_EMIT
   } back_state_type;

endpackage

`default_nettype wire

// ===== src/lowest_free_room_scheduler.sv =====
// ----------------------------------------------------------------------------
// lowest_free_room_scheduler
// Books meeting requests into the lowest free room, reports most-booked room.
// ----------------------------------------------------------------------------
// Requests are queued (4 deep) on push/full and handled one at a time by a
// sequencer that walks the room table through a single registered read port,
// one room per cycle over the n rooms in use (room_count clamped to 1..ROOMS).
// A request marked last adds a second walk over the booking counts, then posts
// one word on the result side and clears all rooms for the next set. Rooms are
// cleared through per-room valid bits, so no clearing pass follows reset.
// room_count is written on the csr channel, which is always ready; write it
// only while no request is in flight.
`default_nettype none

module lowest_free_room_scheduler #(
   parameter int ROOMS     = lfrs_pkg::ROOMS_DEF,
   parameter int TIME_BITS = lfrs_pkg::TIME_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   output logic                                 req_full,
   input  wire logic [lfrs_pkg::IN_TIME_W-1:0]  req_start_time,
   input  wire logic [lfrs_pkg::IN_TIME_W-1:0]  req_end_time,
   input  wire logic                            req_last_request,
   output logic                                 rsp_empty,
   input  wire logic                            rsp_pop,
   output logic [lfrs_pkg::ROOM_OUT_W-1:0]      rsp_most_booked_room,
   output logic [lfrs_pkg::COUNT_W-1:0]         rsp_booking_total,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [lfrs_pkg::CFG_W-1:0]      csr_room_count
);
   import lfrs_pkg::*;

   localparam int NW = $clog2(ROOMS + 1);

   logic [CFG_W-1:0] room_count_ff;
   logic [31:0]      rc_ext;
   logic [31:0]      rooms_used;
   logic [NW-1:0]    room_num;
   logic             item_valid;
   item_type         item;
   logic             item_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         room_count_ff <= ROOM_COUNT_RST;
      end else if (csr_valid && csr_ready) begin
         room_count_ff <= csr_room_count;
      end
   end

   // zero counts as one room, anything above capacity as full capacity
   always_comb begin
      rc_ext = 32'(room_count_ff);
      if (rc_ext == 32'd0) begin
         rooms_used = 32'd1;
      end else if (rc_ext > 32'(ROOMS)) begin
         rooms_used = 32'(ROOMS);
      end else begin
         rooms_used = rc_ext;
      end
      room_num = NW'(rooms_used);
   end

   lfrs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_start_time   (req_start_time),
      .req_end_time     (req_end_time),
      .req_last_request (req_last_request),
      .item_valid       (item_valid),
      .item             (item),
      .item_pop         (item_pop)
   );

   lfrs_back #(
      .ROOMS     (ROOMS),
      .TIME_BITS (TIME_BITS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .room_num             (room_num),
      .item_valid           (item_valid),
      .item                 (item),
      .item_pop             (item_pop),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_most_booked_room (rsp_most_booked_room),
      .rsp_booking_total    (rsp_booking_total)
   );

endmodule

`default_nettype wire

// ===== src/lfrs_front.sv =====
// ----------------------------------------------------------------------------
// lfrs_front
// Accepts requests, derives the meeting duration and queues them for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module lfrs_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic [lfrs_pkg::IN_TIME_W-1:0] req_start_time,
   input  wire logic [lfrs_pkg::IN_TIME_W-1:0] req_end_time,
   input  wire logic                          req_last_request,
   output logic                               item_valid,
   output lfrs_pkg::item_type                 item,
   input  wire logic                          item_pop
);
   import lfrs_pkg::*;

   item_type                 queue_mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]     fill_ff, fill_in;
   logic                     push_ok;
   logic                     pop_ok;
   item_type                 new_item;

   // end before start gives a zero-length meeting
   always_comb begin
      new_item.start_time   = req_start_time;
      new_item.last_request = req_last_request;
      if (req_end_time >= req_start_time) begin
         new_item.duration = req_end_time - req_start_time;
      end else begin
         new_item.duration = '0;
      end
   end

   assign req_full   = (fill_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign item_valid = (fill_ff != '0);
   assign item       = queue_mem[rd_ptr_ff];
   assign push_ok    = req_push && !req_full;
   assign pop_ok     = item_pop && item_valid;

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push_ok && !pop_ok) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_mem[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

// ===== src/lfrs_back.sv =====
// ----------------------------------------------------------------------------
// lfrs_back
// Room table, per-request scan sequencer, booking update and report register.
// ----------------------------------------------------------------------------
`default_nettype none

module lfrs_back #(
   parameter int ROOMS     = lfrs_pkg::ROOMS_DEF,
   parameter int TIME_BITS = lfrs_pkg::TIME_BITS_DEF,
   localparam int RW = (ROOMS > 1) ? $clog2(ROOMS) : 1,
   localparam int NW = $clog2(ROOMS + 1)
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [NW-1:0]                  room_num,
   input  wire logic                           item_valid,
   input  wire lfrs_pkg::item_type             item,
   output logic                                item_pop,
   output logic                                rsp_empty,
   input  wire logic                           rsp_pop,
   output logic [lfrs_pkg::ROOM_OUT_W-1:0]     rsp_most_booked_room,
   output logic [lfrs_pkg::COUNT_W-1:0]        rsp_booking_total
);
   import lfrs_pkg::*;

   localparam int CW = ((TIME_BITS > IN_TIME_W) ? TIME_BITS : IN_TIME_W) + 1;
   localparam logic [CW-1:0] TMAX_C = {{(CW-TIME_BITS){1'b0}}, {TIME_BITS{1'b1}}};

   back_state_type          state_ff, state_in;

   logic [TIME_BITS-1:0]    busy_mem [ROOMS];
   logic [COUNT_W-1:0]      cnt_mem  [ROOMS];
   logic [ROOMS-1:0]        valid_ff;

   logic [NW-1:0]           idx_ff, idx_in;
   logic                    rd_pend_ff;
   logic [RW-1:0]           rd_idx_ff;
   logic [TIME_BITS-1:0]    busy_rd_ff;
   logic [COUNT_W-1:0]      cnt_rd_ff;
   logic                    vld_rd_ff;

   logic                    found_ff;
   logic [RW-1:0]           sel_idx_ff;
   logic [COUNT_W-1:0]      sel_cnt_ff;
   logic [RW-1:0]           min_idx_ff;
   logic [TIME_BITS-1:0]    min_busy_ff;
   logic [COUNT_W-1:0]      min_cnt_ff;
   logic [RW-1:0]           best_idx_ff;
   logic [COUNT_W-1:0]      best_cnt_ff;

   logic                    out_valid_ff;
   logic [ROOM_OUT_W-1:0]   out_room_ff;
   logic [COUNT_W-1:0]      out_total_ff;

   logic                    scanning;
   logic                    rd_issue;
   logic                    scan_done;
   logic                    wr_en;
   logic                    emit;
   logic                    clr_idx;

   logic [TIME_BITS-1:0]    eff_busy;
   logic [COUNT_W-1:0]      eff_cnt;
   logic [RW-1:0]           wr_addr;
   logic [COUNT_W-1:0]      cur_cnt;
   logic [COUNT_W-1:0]      new_cnt;
   logic [CW-1:0]           sum_c;
   logic [TIME_BITS-1:0]    new_busy;

   assign scan_done = (idx_ff == room_num) && !rd_pend_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (item_valid) state_in = B_SCAN;
         end
         B_SCAN: begin
            if (scan_done) state_in = B_UPDATE;
         end
         B_UPDATE: begin
            state_in = item.last_request ? B_REPORT : B_IDLE;
         end
         B_REPORT: begin
            if (scan_done) state_in = B_EMIT;
         end
         B_EMIT: begin
            if (!out_valid_ff || rsp_pop) state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   // control decode
   always_comb begin
      scanning = 1'b0;
      wr_en    = 1'b0;
      emit     = 1'b0;
      clr_idx  = 1'b0;
      case (state_ff)
         B_IDLE:   clr_idx  = 1'b1;
         B_SCAN:   scanning = 1'b1;
         B_UPDATE: begin
            wr_en   = 1'b1;
            clr_idx = 1'b1;
         end
         B_REPORT: scanning = 1'b1;
         B_EMIT:   emit     = !out_valid_ff || rsp_pop;
         default:  clr_idx  = 1'b1;
      endcase
   end

   assign rd_issue = scanning && (idx_ff < room_num);
   assign item_pop = wr_en;

   always_comb begin
      idx_in = idx_ff;
      if (clr_idx) begin
         idx_in = '0;
      end else if (rd_issue) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   // entries not written since the last clear read as zero
   assign eff_busy = vld_rd_ff ? busy_rd_ff : '0;
   assign eff_cnt  = vld_rd_ff ? cnt_rd_ff  : '0;

   // booking update: free room starts at request start, else at room's free time
   always_comb begin
      wr_addr = found_ff ? sel_idx_ff : min_idx_ff;
      cur_cnt = found_ff ? sel_cnt_ff : min_cnt_ff;
      new_cnt = (cur_cnt == '1) ? cur_cnt : cur_cnt + 1'b1;
      sum_c   = (found_ff ? CW'(item.start_time) : CW'(min_busy_ff)) + CW'(item.duration);
      new_busy = (sum_c > TMAX_C) ? TMAX_C[TIME_BITS-1:0] : sum_c[TIME_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         idx_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         valid_ff     <= '0;
         found_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         rd_pend_ff <= rd_issue;
         if (emit) begin
            valid_ff <= '0;
         end else if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (state_ff == B_IDLE) begin
            found_ff <= 1'b0;
         end else if (state_ff == B_SCAN && rd_pend_ff && !found_ff &&
                      (CW'(eff_busy) <= CW'(item.start_time))) begin
            found_ff <= 1'b1;
         end
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // room table, one read and one write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         busy_mem[wr_addr] <= new_busy;
         cnt_mem[wr_addr]  <= new_cnt;
      end
      if (rd_issue) begin
         busy_rd_ff <= busy_mem[idx_ff[RW-1:0]];
         cnt_rd_ff  <= cnt_mem[idx_ff[RW-1:0]];
         vld_rd_ff  <= valid_ff[idx_ff[RW-1:0]];
         rd_idx_ff  <= idx_ff[RW-1:0];
      end
   end

   // scan accumulators
   always_ff @(posedge clock) begin
      if (rd_pend_ff && state_ff == B_SCAN) begin
         if (!found_ff && (CW'(eff_busy) <= CW'(item.start_time))) begin
            sel_idx_ff <= rd_idx_ff;
            sel_cnt_ff <= eff_cnt;
         end
         if (rd_idx_ff == '0 || eff_busy < min_busy_ff) begin
            min_idx_ff  <= rd_idx_ff;
            min_busy_ff <= eff_busy;
            min_cnt_ff  <= eff_cnt;
         end
      end
      if (rd_pend_ff && state_ff == B_REPORT) begin
         if (rd_idx_ff == '0 || eff_cnt > best_cnt_ff) begin
            best_idx_ff <= rd_idx_ff;
            best_cnt_ff <= eff_cnt;
         end
      end
      if (emit) begin
         out_room_ff  <= ROOM_OUT_W'(best_idx_ff);
         out_total_ff <= best_cnt_ff;
      end
   end

   assign rsp_empty            = !out_valid_ff;
   assign rsp_most_booked_room = out_room_ff;
   assign rsp_booking_total    = out_total_ff;

`include "lowest_free_room_scheduler_assert.svh"

   `LFRS_ASSERT_NOW(a_wr_in_range, clock, reset, wr_en, NW'(wr_addr) < room_num, "room write beyond rooms in use")
   `LFRS_ASSERT_NOW(a_update_has_item, clock, reset, state_ff == B_UPDATE, item_valid, "update without queued request")
   `LFRS_ASSERT_NEXT(a_emit_clears, clock, reset, emit, valid_ff == '0 && !rsp_empty, "report did not clear rooms or post word")

endmodule

`default_nettype wire

// ===== verif/booking_scoreboard_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// booking_scoreboard_pkg
// Room booking predictor and report checker for the scheduler testbench.
// ----------------------------------------------------------------------------
// Each accepted request is booked into a private copy of the room table.
// A last request yields the expected most-booked report and clears the table.
package booking_scoreboard_pkg;

   import lfrs_pkg::*;

   localparam int ROOMS     = ROOMS_DEF;
   localparam int TIME_BITS = TIME_BITS_DEF;

   localparam logic [63:0]        TIME_LIMIT  = (64'd1 << TIME_BITS) - 64'd1;
   localparam logic [COUNT_W-1:0] COUNT_LIMIT = '1;

   typedef struct {
      logic [ROOM_OUT_W-1:0] room;
      logic [COUNT_W-1:0]    total;
   } booking_report_type;

   class booking_scoreboard;

      logic [63:0]        room_busy_until [ROOMS];
      logic [COUNT_W-1:0] room_bookings   [ROOMS];
      logic [CFG_W-1:0]   room_count;
      booking_report_type pending_reports [$];
      int                 error_count;

      function new();
         room_count  = ROOM_COUNT_RST;
         error_count = 0;
         clear_rooms();
      endfunction

      function void clear_rooms();
         int i;
         for (i = 0; i < ROOMS; i++) begin
            room_busy_until[i] = '0;
            room_bookings[i]   = '0;
         end
      endfunction

      function void set_room_count(logic [CFG_W-1:0] value);
         room_count = value;
      endfunction

      function int pending_count();
         return pending_reports.size();
      endfunction

      function void book_request(logic [IN_TIME_W-1:0] start_time,
                                 logic [IN_TIME_W-1:0] end_time,
                                 logic                 last_request);
         logic [63:0]        start_w;
         logic [63:0]        dur;
         logic [63:0]        stop;
         logic [63:0]        base;
         int                 n;
         int                 room;
         int                 best;
         int                 i;
         booking_report_type rep;
         start_w = 64'(start_time);
         dur     = (end_time >= start_time) ? 64'(end_time - start_time) : 64'd0;
         n = int'(room_count);
         if (n < 1) n = 1;
         if (n > ROOMS) n = ROOMS;
         room = n;
         for (i = 0; i < n; i++) begin
            if (room == n && room_busy_until[i] <= start_w) room = i;
         end
         if (room < n) begin
            stop = start_w + dur;
            room_busy_until[room] = (stop > TIME_LIMIT) ? TIME_LIMIT : stop;
         end else begin
            // all busy: earliest-freeing room, meeting slides but keeps length up to the time limit
            room = 0;
            for (i = 1; i < n; i++) begin
               if (room_busy_until[i] < room_busy_until[room]) room = i;
            end
            base = room_busy_until[room];
            room_busy_until[room] = (base > TIME_LIMIT - dur) ? TIME_LIMIT : base + dur;
         end
         if (room_bookings[room] != COUNT_LIMIT) room_bookings[room]++;
         if (last_request) begin
            best = 0;
            for (i = 1; i < n; i++) begin
               if (room_bookings[i] > room_bookings[best]) best = i;
            end
            rep.room  = ROOM_OUT_W'(best);
            rep.total = room_bookings[best];
            pending_reports.push_back(rep);
            clear_rooms();
         end
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         error_count++;
      endtask

      task check_report(logic [ROOM_OUT_W-1:0] room, logic [COUNT_W-1:0] total);
         booking_report_type want;
         if (pending_reports.size() == 0) begin
            report_mismatch($sformatf("unexpected word room %0d total %0d", room, total));
         end else begin
            want = pending_reports.pop_front();
            if (room !== want.room)
               report_mismatch($sformatf("most_booked_room %0d, want %0d", room, want.room));
            if (total !== want.total)
               report_mismatch($sformatf("booking_total %0d, want %0d", total, want.total));
         end
      endtask

   endclass

endpackage

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Random and directed meeting sets against the lowest-free-room scheduler.
// ----------------------------------------------------------------------------
// Sets of requests with random timing end in a last request; each report is
// checked against the scoreboard. room_count is rewritten between phases,
// out-of-range values included, while sender and receiver idle at random.
module tb;

   import lfrs_pkg::*;
   import booking_scoreboard_pkg::*;

   localparam int                   CYCLE_LIMIT  = 1000000;
   localparam int                   DRAIN_CYCLES = 400;
   localparam int                   PHASES       = 8;
   localparam int                   PHASE_ITEMS  = 205;
   localparam logic [IN_TIME_W-1:0] TIME_MAX     = '1;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_push = 1'b0;
   logic                   req_full;
   logic [IN_TIME_W-1:0]   req_start_time = '0;
   logic [IN_TIME_W-1:0]   req_end_time = '0;
   logic                   req_last_request = 1'b0;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   logic [ROOM_OUT_W-1:0]  rsp_most_booked_room;
   logic [COUNT_W-1:0]     rsp_booking_total;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CFG_W-1:0]       csr_room_count = '0;

   booking_scoreboard sb;
   int                send_idle_pct = 0;
   int                recv_stall_pct = 0;
   int                cycle_count = 0;

   lowest_free_room_scheduler u_top (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_start_time       (req_start_time),
      .req_end_time         (req_end_time),
      .req_last_request     (req_last_request),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_most_booked_room (rsp_most_booked_room),
      .rsp_booking_total    (rsp_booking_total),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_room_count       (csr_room_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // monitors: handshakes sampled at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full)
            sb.book_request(req_start_time, req_end_time, req_last_request);
         if (rsp_pop && !rsp_empty)
            sb.check_report(rsp_most_booked_room, rsp_booking_total);
         if (csr_valid && csr_ready)
            sb.set_room_count(csr_room_count);
      end
   end

   always @(negedge clock) begin
      rsp_pop = ($urandom_range(0, 99) >= recv_stall_pct);
   end

   function automatic logic [IN_TIME_W-1:0] sat_add(logic [IN_TIME_W-1:0] a,
                                                    logic [IN_TIME_W-1:0] b);
      logic [IN_TIME_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[IN_TIME_W] ? TIME_MAX : sum[IN_TIME_W-1:0];
   endfunction

   function automatic logic [IN_TIME_W-1:0] sat_sub(logic [IN_TIME_W-1:0] a,
                                                    logic [IN_TIME_W-1:0] b);
      return (a > b) ? a - b : '0;
   endfunction

   task automatic send_request(logic [IN_TIME_W-1:0] start_t,
                               logic [IN_TIME_W-1:0] end_t,
                               logic                 last_t);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_push = 1'b0;
         @(negedge clock);
      end
      req_push         = 1'b1;
      req_start_time   = start_t;
      req_end_time     = end_t;
      req_last_request = last_t;
      @(posedge clock);
      while (req_full) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained(int settle);
      req_push = 1'b0;
      while (sb.pending_count() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_room_count(logic [CFG_W-1:0] value);
      wait_drained(DRAIN_CYCLES);
      csr_valid      = 1'b1;
      csr_room_count = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin
      int                   room_setting [PHASES];
      int                   phase;
      int                   sent;
      int                   set_len;
      int                   k;
      bit                   paused;
      logic [IN_TIME_W-1:0] cursor;
      logic [IN_TIME_W-1:0] dur;
      logic [IN_TIME_W-1:0] start_t;
      logic [IN_TIME_W-1:0] end_t;
      sb = new();
      room_setting = '{16, 1, 31, 5, 0, 17, 3, 16};
      paused = 1'b0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // single meeting, room count above capacity
      write_room_count(5'd31);
      send_request('0, '0, 1'b1);
      // end before start gives zero length
      send_request(40'd5, 40'd100, 1'b0);
      send_request(40'd6, 40'd100, 1'b0);
      send_request(40'd7, 40'd3, 1'b1);
      // room count zero acts as one room: second meeting slides
      write_room_count(5'd0);
      send_request(40'd10, 40'd20, 1'b0);
      send_request(40'd12, 40'd15, 1'b0);
      send_request(40'd30, 40'd40, 1'b1);
      // top of the time range, tie on earliest-free, out-of-order start
      write_room_count(5'd2);
      send_request(TIME_MAX - 40'd5, TIME_MAX, 1'b0);
      send_request(TIME_MAX - 40'd5, TIME_MAX, 1'b0);
      send_request(TIME_MAX - 40'd4, TIME_MAX - 40'd4, 1'b0);
      send_request(40'd100, TIME_MAX, 1'b0);
      send_request(TIME_MAX, TIME_MAX, 1'b1);
      // all rooms busy
      write_room_count(5'd3);
      for (k = 0; k < 4; k++) send_request('0, 40'd1000, k == 3);
      send_request(40'h55_5555_5555, 40'hAA_AAAA_AAAA, 1'b1);

      for (phase = 0; phase < PHASES; phase++) begin
         write_room_count((phase == 6) ? CFG_W'($urandom_range(0, 31))
                                       : CFG_W'(room_setting[phase]));
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            default: begin send_idle_pct = 32; recv_stall_pct = 32; end
         endcase
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            case ($urandom_range(0, 9))
               0:       set_len = 1;
               1, 2:    set_len = $urandom_range(25, 60);
               default: set_len = $urandom_range(2, 24);
            endcase
            case ($urandom_range(0, 3))
               0:       cursor = '0;
               1:       cursor = IN_TIME_W'($urandom_range(0, 1000));
               2:       cursor = {8'($urandom_range(0, 255)), 32'($urandom)};
               default: cursor = TIME_MAX - IN_TIME_W'($urandom_range(0, 2000));
            endcase
            for (k = 0; k < set_len; k++) begin
               if ($urandom_range(0, 9) < 7)
                  cursor = sat_add(cursor, IN_TIME_W'($urandom_range(0, 4)));
               else
                  cursor = sat_add(cursor, IN_TIME_W'($urandom_range(5, 60)));
               case ($urandom_range(0, 19))
                  0:       dur = {8'($urandom_range(0, 255)), 32'($urandom)};
                  1, 2:    dur = IN_TIME_W'($urandom_range(0, 5000));
                  default: dur = IN_TIME_W'($urandom_range(0, 120));
               endcase
               start_t = cursor;
               if ($urandom_range(0, 24) == 0)
                  start_t = sat_sub(cursor, IN_TIME_W'($urandom_range(1, 100)));
               if ($urandom_range(0, 24) == 0)
                  end_t = sat_sub(start_t, IN_TIME_W'($urandom_range(1, 50)));
               else
                  end_t = sat_add(start_t, dur);
               send_request(start_t, end_t, k == set_len - 1);
               sent++;
            end
            // hold the sender off until every report is back
            if (phase == 1 && !paused) begin
               wait_drained(0);
               paused = 1'b1;
            end
         end
      end

      wait_drained(DRAIN_CYCLES);
      if (sb.error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
